[rtl/core/bdws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdws_pkg
// Shared types and constants for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdws_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_VALUE_BITS = 32;
  localparam int OP_BITS        = 3;
  localparam int STATUS_BITS    = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DONE
  } state_t;

  // Row-wide move command: shr moves every entry one cell back,
  // shl moves every entry one cell towards the front.
  typedef struct packed {
    logic shl;
    logic shr;
  } cell_ctrl_t;

endpackage

[rtl/core/bdws_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdws_cell
// One storage cell of the deque row; takes a neighbour's entry or a new value.
// ----------------------------------------------------------------------------
module bdws_cell #(
  parameter int VALUE_BITS = bdws_pkg::DEF_VALUE_BITS
) (
  input  logic                   clk,
  input  bdws_pkg::cell_ctrl_t   ctrl,
  input  logic                   load,
  input  logic [VALUE_BITS-1:0]  value_in,
  input  logic [VALUE_BITS-1:0]  left_data,
  input  logic [VALUE_BITS-1:0]  right_data,
  output logic [VALUE_BITS-1:0]  data
);
  import bdws_pkg::*;

  // Payload only: no reset.
  always_ff @(posedge clk) begin
    priority if (ctrl.shr) begin
      data <= left_data;
    end else if (ctrl.shl) begin
      data <= right_data;
    end else if (load) begin
      data <= value_in;
    end else begin
      // Hold
      data <= data;
    end
  end

endmodule

[rtl/core/bounded_deque_with_search_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit
// Bounded deque of signed values held in a row of cells, front entry in cell 0.
// Push front, push back and pop front go through ST_EXEC to the result register.
// Pop back (not empty) and search go on to ST_WALK and ST_DONE; the row rotates once
// through cell 0, where a single comparator checks one entry per cycle.
// One request is in work at a time; a new one is taken while a result waits.
// Reset (rst, synchronous) empties the deque; cell contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_unit #(
  parameter int CAPACITY   = bdws_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = bdws_pkg::DEF_VALUE_BITS,
  localparam int POS_W     = $clog2(CAPACITY),
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IN_BITS   = bdws_pkg::OP_BITS + VALUE_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = bdws_pkg::STATUS_BITS + 1 + POS_W + VALUE_BITS + CNT_W,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // op, value (from bit 0 up)
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status, found, position, removed_value, element_count (from bit 0 up)
  output logic [OUT_W-1:0] m_tdata
);
  import bdws_pkg::*;

  localparam logic [POS_W-1:0] LAST_STEP = POS_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

  state_t state, state_next;

  // Request held for the duration of the operation
  op_t                    op_q;
  logic [VALUE_BITS-1:0]  value_q;

  // Deque occupancy
  logic [CNT_W-1:0]       count, count_next;

  // Walk bookkeeping
  logic [POS_W-1:0]       step;
  logic                   hit;
  logic [POS_W-1:0]       hit_pos;
  logic [VALUE_BITS-1:0]  back_value;

  // Result register
  status_t                status_q, status_next;
  logic                   found_q, found_next;
  logic [POS_W-1:0]       pos_q, pos_next;
  logic [VALUE_BITS-1:0]  removed_q, removed_next;
  logic [CNT_W-1:0]       count_q;

  logic                   in_accept;
  logic                   out_free;
  logic                   res_write;
  logic                   need_walk;
  logic                   load_back;
  cell_ctrl_t             ctrl;

  logic [VALUE_BITS-1:0]  cell_data [CAPACITY];
  logic [VALUE_BITS-1:0]  head_data;

  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign head_data = cell_data[0];
  // Search always walks; pop back walks only when there is something to take
  assign need_walk = (op_q == OP_SEARCH) || ((op_q == OP_POP_BACK) && (count != '0));

  assign m_tdata = OUT_W'({count_q, removed_q, pos_q, found_q, status_q});

  // --------------------------------------------------------------------------
  // Cell row: cell 0 is the front. Shifting back feeds the new value into
  // cell 0; shifting to the front wraps cell 0 round to the last cell, so
  // CAPACITY such moves restore the original order.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_d;
    logic [VALUE_BITS-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = value_q;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[0];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    bdws_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load       (load_back && (count == CNT_W'(i))),
      .value_in   (value_q),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (need_walk) begin
          state_next = ST_WALK;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (step == LAST_STEP) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control and result formation
  // --------------------------------------------------------------------------
  always_comb begin
    ctrl         = '0;
    load_back    = 1'b0;
    res_write    = 1'b0;
    status_next  = STATUS_OK;
    found_next   = 1'b0;
    pos_next     = '0;
    removed_next = '0;
    count_next   = count;
    unique case (state)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        if (!need_walk && out_free) begin
          res_write = 1'b1;
          unique case (op_q)
            OP_PUSH_FRONT: begin
              if (count == FULL_CNT) begin
                status_next = STATUS_FULL;
              end else begin
                ctrl.shr   = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (count == FULL_CNT) begin
                status_next = STATUS_FULL;
              end else begin
                load_back  = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count == '0) begin
                status_next = STATUS_EMPTY;
              end else begin
                removed_next = head_data;
                ctrl.shl     = 1'b1;
                count_next   = count - 1'b1;
              end
            end
            OP_POP_BACK: begin
              // Only reached with an empty deque
              status_next = STATUS_EMPTY;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        ctrl.shl = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          res_write = 1'b1;
          if (op_q == OP_POP_BACK) begin
            removed_next = back_value;
            count_next   = count - 1'b1;
          end else begin
            found_next = hit;
            pos_next   = hit ? hit_pos : '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      step     <= '0;
      hit      <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_write) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // Clear the walk before it starts, advance it with every shift of the row
      if (state == ST_EXEC) begin
        step <= '0;
        hit  <= 1'b0;
      end else if (state == ST_WALK) begin
        step <= step + 1'b1;
        if (!hit && (CNT_W'(step) < count) && (head_data == value_q)) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q    <= op_t'(s_tdata[OP_BITS-1:0]);
      value_q <= s_tdata[OP_BITS +: VALUE_BITS];
    end
    if (state == ST_WALK) begin
      // Record the first match; the entry at the back passes cell 0 last
      if (!hit && (CNT_W'(step) < count) && (head_data == value_q)) begin
        hit_pos <= step;
      end
      if (CNT_W'(step) == count - 1'b1) begin
        back_value <= head_data;
      end
    end
    if (res_write) begin
      status_q  <= status_next;
      found_q   <= found_next;
      pos_q     <= pos_next;
      removed_q <= removed_next;
      count_q   <= count_next;
    end
  end

`ifndef SYNTHESIS
  // Occupancy never goes beyond the row length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("deque count exceeds capacity");

  // Occupancy moves only when a result is written
  a_count_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(res_write))
    else $error("deque count changed without a result");

  // A walk runs its full rotation before finishing
  a_walk_full_turn: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && step != LAST_STEP) |=> (state == ST_WALK))
    else $error("walk left before a full rotation");

  // A full status is given only with a full deque
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_write && status_next == STATUS_FULL) |-> (count == FULL_CNT))
    else $error("full status reported with free cells");
`endif

endmodule

[verif/deque_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches both stream channels of the bounded deque. Each accepted request is
// run through a local model of the deque, and each accepted result is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module deque_result_checker #(
  parameter int CAPACITY   = bdws_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = bdws_pkg::DEF_VALUE_BITS,
  localparam int POS_W     = $clog2(CAPACITY),
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IN_W      = ((bdws_pkg::OP_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = bdws_pkg::STATUS_BITS + 1 + POS_W + VALUE_BITS + CNT_W,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  // op, value (from bit 0 up)
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  // status, found, position, removed_value, element_count (from bit 0 up)
  input  logic [OUT_W-1:0] m_tdata,
  output int unsigned      error_count,
  output int unsigned      pending_results
);
  import bdws_pkg::*;

  localparam int FOUND_LSB   = STATUS_BITS;
  localparam int POS_LSB     = FOUND_LSB + 1;
  localparam int REMOVED_LSB = POS_LSB + POS_W;
  localparam int COUNT_LSB   = REMOVED_LSB + VALUE_BITS;

  typedef struct {
    status_t               status;
    logic                  found;
    logic [POS_W-1:0]      position;
    logic [VALUE_BITS-1:0] removed;
    logic [CNT_W-1:0]      count;
  } deque_outcome_t;

  logic [VALUE_BITS-1:0] deque_slots [CAPACITY];
  logic [POS_W-1:0]      front_slot;
  logic [CNT_W-1:0]      fill_level;
  deque_outcome_t        expected_results [$];

  function automatic logic [POS_W-1:0] slot_from_front(input int offset);
    return POS_W'((int'(front_slot) + offset) % CAPACITY);
  endfunction

  // Advance the local deque by one request and work out the result it gives.
  task automatic apply_deque_op(input logic [OP_BITS-1:0] op,
                                input logic [VALUE_BITS-1:0] value,
                                output deque_outcome_t res);
    res.status   = STATUS_OK;
    res.found    = 1'b0;
    res.position = '0;
    res.removed  = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (fill_level >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          front_slot = POS_W'((int'(front_slot) + CAPACITY - 1) % CAPACITY);
          deque_slots[front_slot] = value;
          fill_level++;
        end
      end
      OP_PUSH_BACK: begin
        if (fill_level >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          deque_slots[slot_from_front(int'(fill_level))] = value;
          fill_level++;
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.removed = deque_slots[front_slot];
          front_slot  = slot_from_front(1);
          fill_level--;
        end
      end
      OP_POP_BACK: begin
        if (fill_level == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.removed = deque_slots[slot_from_front(int'(fill_level) - 1)];
          fill_level--;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < int'(fill_level); i++) begin
          if (!res.found && deque_slots[slot_from_front(i)] == value) begin
            res.found    = 1'b1;
            res.position = POS_W'(i);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = fill_level;
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    deque_outcome_t got;
    deque_outcome_t want;
    deque_outcome_t predicted;
    if (rst) begin
      front_slot = '0;
      fill_level = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status   = status_t'(m_tdata[STATUS_BITS-1:0]);
        got.found    = m_tdata[FOUND_LSB];
        got.position = m_tdata[POS_LSB +: POS_W];
        got.removed  = m_tdata[REMOVED_LSB +: VALUE_BITS];
        got.count    = m_tdata[COUNT_LSB +: CNT_W];
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status: got %0d, expected %0d",
                                      got.status, want.status));
          if (got.found !== want.found)
            report_mismatch($sformatf("found: got %0b, expected %0b",
                                      got.found, want.found));
          if (got.position !== want.position)
            report_mismatch($sformatf("position: got %0d, expected %0d",
                                      got.position, want.position));
          if (got.removed !== want.removed)
            report_mismatch($sformatf("removed_value: got %0d, expected %0d",
                                      $signed(got.removed), $signed(want.removed)));
          if (got.count !== want.count)
            report_mismatch($sformatf("element_count: got %0d, expected %0d",
                                      got.count, want.count));
        end
      end
      if (s_tvalid && s_tready) begin
        apply_deque_op(s_tdata[OP_BITS-1:0], s_tdata[OP_BITS +: VALUE_BITS], predicted);
        expected_results.push_back(predicted);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the bounded deque with search and takes its results,
// both sides idling at random. A directed opening walks the deque through
// empty, full and wrap-around; random phases then grow, shrink and churn it.
// Checking is left to deque_result_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import bdws_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int VALUE_BITS   = DEF_VALUE_BITS;
  localparam int POS_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int IN_W         = ((OP_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_W        = ((STATUS_BITS + 1 + POS_W + VALUE_BITS + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_STALL   = 80;
  localparam int RECENT_DEPTH = 8;
  localparam int CYCLE_LIMIT  = 300000;

  // Op codes the block treats as no operation.
  localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VALUE_DUP = 32'hA5A5_5A5A;

  // Bias of the request mix within one random phase.
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } op_mix_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  // op, value (from bit 0 up)
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  // status, found, position, removed_value, element_count (from bit 0 up)
  logic [OUT_W-1:0] m_tdata;

  int unsigned error_count;
  int unsigned pending_results;
  int unsigned cycle_count;
  int unsigned requests_sent;

  // Shared between the request and result processes.
  logic no_idle;
  logic stall_request;

  // Recently pushed values, so that searches and duplicates actually hit.
  logic [VALUE_BITS-1:0] recent_values [RECENT_DEPTH];
  int unsigned           recent_wr;

  bounded_deque_with_search_unit #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  deque_result_checker #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .error_count    (error_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one request, after a random idle gap (none while no_idle is set), and hold it until taken.
  // Returns at the accepting rising edge with valid still high, so a
  // back-to-back request keeps valid asserted without a drop.
  task automatic send_request(input logic [OP_BITS-1:0] op,
                              input logic [VALUE_BITS-1:0] value);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata                        = '0;
    s_tdata[OP_BITS-1:0]           = op;
    s_tdata[OP_BITS +: VALUE_BITS] = value;
    s_tvalid                       = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      recent_values[recent_wr] = value;
      recent_wr = (recent_wr + 1) % RECENT_DEPTH;
    end
  endtask

  // Drop valid so that the last request is not taken twice.
  task automatic park_source();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_results();
    park_source();
    while (pending_results != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return recent_values[$urandom_range(0, RECENT_DEPTH - 1)];
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       return VALUE_MAX;
        1:       return VALUE_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return VALUE_BITS'($urandom());
  endfunction

  function automatic logic [OP_BITS-1:0] pick_op(input op_mix_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 35) return OP_PUSH_FRONT;
        if (r < 70) return OP_PUSH_BACK;
        if (r < 76) return OP_POP_FRONT;
        if (r < 82) return OP_POP_BACK;
        if (r < 97) return OP_SEARCH;
      end
      MIX_SHRINK: begin
        if (r < 10) return OP_PUSH_FRONT;
        if (r < 20) return OP_PUSH_BACK;
        if (r < 47) return OP_POP_FRONT;
        if (r < 74) return OP_POP_BACK;
        if (r < 97) return OP_SEARCH;
      end
      default: begin
        if (r < 20) return OP_PUSH_FRONT;
        if (r < 40) return OP_PUSH_BACK;
        if (r < 58) return OP_POP_FRONT;
        if (r < 76) return OP_POP_BACK;
        if (r < 97) return OP_SEARCH;
      end
    endcase
    // A small share of noise: the unused op codes.
    return OP_BITS'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // Result side: random back-pressure, plus a long hold-off when asked.
  initial begin : result_sink
    int unsigned gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_request) begin
        m_tready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_request = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Request side: reset, directed opening, random phases, verdict.
  initial begin : request_source
    int unsigned random_target;
    int unsigned phase_len;
    int unsigned phase_no;
    op_mix_t     mix;

    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    no_idle       = 1'b0;
    stall_request = 1'b0;
    requests_sent = 0;
    recent_wr     = 0;
    for (int i = 0; i < RECENT_DEPTH; i++) recent_values[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty deque: search, both pops and an unused op must leave it alone.
    send_request(OP_SEARCH, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '1);
    send_request(OP_UNUSED_LO, VALUE_MAX);

    // Extremes in and out again; the last pop empties the deque.
    send_request(OP_PUSH_FRONT, VALUE_MAX);
    send_request(OP_PUSH_BACK, VALUE_MIN);
    send_request(OP_SEARCH, VALUE_MIN);
    send_request(OP_SEARCH, 32'h0000_1234);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_FRONT, '0);

    // Fill to capacity from both ends, with a duplicated value inside, so
    // the index wraps and the search must report the first match.
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 3 || i == 9)
        send_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, VALUE_DUP);
      else
        send_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, VALUE_BITS'(i * 32'h1111_1111));
    end
    send_request(OP_SEARCH, VALUE_DUP);
    send_request(OP_PUSH_BACK, '1);
    // Last back push sits at the far end of the deque.
    send_request(OP_SEARCH, VALUE_BITS'((CAPACITY - 1) * 32'h1111_1111));
    send_request(OP_POP_BACK, '0);
    drain_results();

    // Random phases: grow, shrink and churn the deque in turn.
    random_target = requests_sent + RANDOM_ITEMS;
    phase_no      = 0;
    while (requests_sent < random_target) begin
      mix       = op_mix_t'(phase_no % 3);
      phase_len = $urandom_range(20, 50);
      no_idle   = ($urandom_range(0, 3) == 0);
      // Starve the result side for a while so the block fills and stalls.
      if (phase_no == 1 || $urandom_range(0, 9) == 0) stall_request = 1'b1;
      for (int n = 0; n < int'(phase_len); n++) send_request(pick_op(mix), pick_value());
      if (phase_no == 2 || $urandom_range(0, 4) == 0) drain_results();
      phase_no++;
    end

    drain_results();
    no_idle = 1'b0;
    // Allow for a walk still in flight before the verdict.
    repeat (CAPACITY + 4) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bdws_pkg.sv
rtl/core/bdws_cell.sv
rtl/core/bounded_deque_with_search_unit.sv
verif/deque_result_checker.sv
verif/testbench.sv
